### hw/rtl/ytl_pkg.sv
`default_nettype none
package ytl_pkg;

    localparam int FIELD_W   = 16;
    localparam int IND_W     = 17;
    localparam int MAX_TOKS  = 4;
    localparam int TOK_IDX_W = 2;
    localparam int TOK_CNT_W = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [7:0] BYTE_TAB   = 8'd9;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_SPACE = 8'd32;
    localparam logic [7:0] BYTE_HASH  = 8'h23;
    localparam logic [7:0] BYTE_DASH  = 8'h2d;
    localparam logic [7:0] BYTE_COLON = 8'h3a;
    localparam logic [7:0] BYTE_QMARK = 8'h3f;
    localparam logic [7:0] BYTE_TILDE = 8'd126;

    typedef enum logic [2:0] {
        KIND_NEWLINE  = 3'd0,
        KIND_BLANKS   = 3'd1,
        KIND_SEQUENCE = 3'd2,
        KIND_KEY      = 3'd3,
        KIND_VALUE    = 3'd4,
        KIND_SCALAR   = 3'd5,
        KIND_COMMENT  = 3'd6,
        KIND_ERROR    = 3'd7
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [FIELD_W-1:0]       offset;
        logic [FIELD_W-1:0]       length;
        logic signed [IND_W-1:0]  indent;
    } t_token;

    // all tokens raised by one input byte, in order
    typedef struct packed {
        t_token [MAX_TOKS-1:0]   toks;
        logic [TOK_CNT_W-1:0]    count;
        logic                    fin;
    } t_bundle;

endpackage
`default_nettype wire

### hw/rtl/ytl_front.sv
`default_nettype none
module ytl_front #(
    parameter int OFFSET_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_final,
    input  wire logic             i_full,
    output logic                  o_push,
    output ytl_pkg::t_bundle      o_bundle
);
    import ytl_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam logic [OB-1:0] POS_LIMIT = '1;

    typedef enum logic [6:0] {
        M_IDLE    = 7'b0000001,
        M_CR      = 7'b0000010,
        M_BLANKS  = 7'b0000100,
        M_IND     = 7'b0001000,
        M_SCALAR  = 7'b0010000,
        M_COMMENT = 7'b0100000,
        M_ERROR   = 7'b1000000
    } t_mode;

    typedef struct packed {
        t_mode          mode;
        logic [OB-1:0]  start;
        logic [7:0]     lead;
        logic [OB-1:0]  tbc;
        logic           pwb;
        logic [OB-1:0]  spc;
        logic           tab;
        logic           colon;
    } t_lex;

    typedef struct packed {
        t_token first;
        t_token second;
        logic   has_second;
    } t_pair;

    t_lex            r_st, n_st;
    logic [OB-1:0]   r_pos, n_pos;
    t_token [MAX_TOKS-1:0] n_toks;
    logic [TOK_CNT_W-1:0]  n_cnt;
    logic            accept;

    function automatic t_lex lex_clear();
        t_lex s;
        s       = '0;
        s.mode  = M_IDLE;
        return s;
    endfunction

    function automatic logic [FIELD_W-1:0] fld16(input logic [OB-1:0] x);
        logic [OB+FIELD_W-1:0] w;
        w = {{FIELD_W{1'b0}}, x};
        return w[FIELD_W-1:0];
    endfunction

    function automatic logic [IND_W-1:0] fld17(input logic [OB-1:0] x);
        logic [OB+IND_W-1:0] w;
        w = {{IND_W{1'b0}}, x};
        return w[IND_W-1:0];
    endfunction

    function automatic t_token mk_tok(input t_kind k, input logic [OB-1:0] off,
                                      input logic [OB-1:0] len,
                                      input logic signed [IND_W-1:0] ind);
        t_token t;
        t.kind   = k;
        t.offset = fld16(off);
        t.length = fld16(len);
        t.indent = ind;
        return t;
    endfunction

    function automatic logic signed [IND_W-1:0] run_indent(input t_lex s);
        return s.tab ? '1 : $signed(fld17(s.spc));
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == BYTE_SPACE) || (b == BYTE_TAB);
    endfunction

    function automatic logic is_break(input logic [7:0] b);
        return (b == BYTE_LF) || (b == BYTE_CR);
    endfunction

    function automatic logic is_safe(input logic [7:0] b);
        return (b > BYTE_SPACE) && (b <= BYTE_TILDE);
    endfunction

    function automatic logic is_ind(input logic [7:0] b);
        return (b == BYTE_DASH) || (b == BYTE_QMARK) || (b == BYTE_COLON);
    endfunction

    function automatic t_kind ind_kind(input logic [7:0] b);
        t_kind k;
        if (b == BYTE_DASH) begin
            k = KIND_SEQUENCE;
        end else if (b == BYTE_QMARK) begin
            k = KIND_KEY;
        end else begin
            k = KIND_VALUE;
        end
        return k;
    endfunction

    // scalar whose raw bytes end just before endp, then its trimmed blanks
    function automatic t_pair close_pair(input t_lex s, input logic [OB-1:0] endp);
        t_pair r;
        logic [OB-1:0] len;
        len = endp - s.start - s.tbc;
        if (len == OB'(1) && is_ind(s.lead)) begin
            r.first = mk_tok(ind_kind(s.lead), s.start, OB'(1), '0);
        end else begin
            r.first = mk_tok(KIND_SCALAR, s.start, len, '0);
        end
        r.second     = mk_tok(KIND_BLANKS, endp - s.tbc, s.tbc, run_indent(s));
        r.has_second = (s.tbc != '0);
        return r;
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        t_lex          v;
        t_pair         pr;
        logic [OB-1:0] p;
        logic [OB-1:0] e;
        logic [OB-1:0] close_end;
        logic          do_start;
        logic          do_close;
        logic          do_value;
        v         = r_st;
        pr        = '0;
        p         = r_pos;
        e         = r_pos + OB'(1);
        close_end = '0;
        do_start  = 1'b0;
        do_close  = 1'b0;
        do_value  = 1'b0;
        n_toks    = '0;
        n_cnt     = '0;
        n_pos     = r_pos;

        if (r_st.mode == M_ERROR) begin
            if (i_final) begin
                n_toks[n_cnt[TOK_IDX_W-1:0]] = mk_tok(KIND_ERROR, r_st.start, '0, '0);
                n_cnt = n_cnt + TOK_CNT_W'(1);
            end
        end else if (r_pos == POS_LIMIT) begin
            // offset range used up: drop the open token
            v.start = POS_LIMIT;
            v.mode  = M_ERROR;
            n_toks[n_cnt[TOK_IDX_W-1:0]] = mk_tok(KIND_ERROR, POS_LIMIT, '0, '0);
            n_cnt = n_cnt + TOK_CNT_W'(1);
        end else begin
            unique case (r_st.mode)
                M_CR: begin
                    if (i_byte == BYTE_LF) begin
                        n_toks[n_cnt[TOK_IDX_W-1:0]] =
                            mk_tok(KIND_NEWLINE, v.start, OB'(2), '0);
                        n_cnt  = n_cnt + TOK_CNT_W'(1);
                        v.mode = M_IDLE;
                    end else begin
                        n_toks[n_cnt[TOK_IDX_W-1:0]] =
                            mk_tok(KIND_NEWLINE, v.start, OB'(1), '0);
                        n_cnt    = n_cnt + TOK_CNT_W'(1);
                        do_start = 1'b1;
                    end
                end
                M_BLANKS: begin
                    if (is_blank(i_byte)) begin
                        if (i_byte == BYTE_SPACE) begin
                            v.spc = v.spc + OB'(1);
                        end else begin
                            v.tab = 1'b1;
                        end
                    end else begin
                        n_toks[n_cnt[TOK_IDX_W-1:0]] =
                            mk_tok(KIND_BLANKS, v.start, p - v.start, run_indent(v));
                        n_cnt    = n_cnt + TOK_CNT_W'(1);
                        do_start = 1'b1;
                    end
                end
                M_IND: begin
                    if (is_safe(i_byte)) begin
                        v.mode  = M_SCALAR;
                        v.tbc   = '0;
                        v.spc   = '0;
                        v.tab   = 1'b0;
                        v.pwb   = 1'b0;
                        v.colon = (i_byte == BYTE_COLON);
                    end else begin
                        n_toks[n_cnt[TOK_IDX_W-1:0]] =
                            mk_tok(ind_kind(v.lead), v.start, OB'(1), '0);
                        n_cnt    = n_cnt + TOK_CNT_W'(1);
                        do_start = 1'b1;
                    end
                end
                M_SCALAR: begin
                    if (v.colon && (is_blank(i_byte) || is_break(i_byte))) begin
                        // colon before a blank or break is a value indicator
                        v.colon   = 1'b0;
                        do_close  = 1'b1;
                        close_end = p - OB'(1);
                        do_value  = 1'b1;
                        do_start  = 1'b1;
                    end else begin
                        if (v.colon) begin
                            v.colon = 1'b0;
                            v.tbc   = '0;
                            v.spc   = '0;
                            v.tab   = 1'b0;
                            v.pwb   = 1'b0;
                        end
                        if (is_break(i_byte) || (i_byte == BYTE_HASH && v.pwb)) begin
                            do_close  = 1'b1;
                            close_end = p;
                            do_start  = 1'b1;
                        end else if (i_byte == BYTE_COLON) begin
                            v.colon = 1'b1;
                        end else if (is_blank(i_byte)) begin
                            v.tbc = v.tbc + OB'(1);
                            if (i_byte == BYTE_SPACE) begin
                                v.spc = v.spc + OB'(1);
                            end else begin
                                v.tab = 1'b1;
                            end
                            v.pwb = 1'b1;
                        end else begin
                            v.tbc = '0;
                            v.spc = '0;
                            v.tab = 1'b0;
                            v.pwb = 1'b0;
                        end
                    end
                end
                M_COMMENT: begin
                    if (is_break(i_byte)) begin
                        n_toks[n_cnt[TOK_IDX_W-1:0]] =
                            mk_tok(KIND_COMMENT, v.start, p - v.start, '0);
                        n_cnt    = n_cnt + TOK_CNT_W'(1);
                        do_start = 1'b1;
                    end
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase

            if (do_close) begin
                pr = close_pair(v, close_end);
                n_toks[n_cnt[TOK_IDX_W-1:0]] = pr.first;
                n_cnt = n_cnt + TOK_CNT_W'(1);
                if (pr.has_second) begin
                    n_toks[n_cnt[TOK_IDX_W-1:0]] = pr.second;
                    n_cnt = n_cnt + TOK_CNT_W'(1);
                end
                v.mode = M_IDLE;
            end
            if (do_value) begin
                n_toks[n_cnt[TOK_IDX_W-1:0]] = mk_tok(KIND_VALUE, p - OB'(1), OB'(1), '0);
                n_cnt = n_cnt + TOK_CNT_W'(1);
            end
            if (do_start) begin
                v.start = p;
                v.spc   = '0;
                v.tab   = 1'b0;
                v.tbc   = '0;
                v.pwb   = 1'b0;
                v.colon = 1'b0;
                v.mode  = M_IDLE;
                if (i_byte == BYTE_LF) begin
                    n_toks[n_cnt[TOK_IDX_W-1:0]] = mk_tok(KIND_NEWLINE, p, OB'(1), '0);
                    n_cnt = n_cnt + TOK_CNT_W'(1);
                end else if (i_byte == BYTE_CR) begin
                    v.mode = M_CR;
                end else if (is_blank(i_byte)) begin
                    v.mode = M_BLANKS;
                    v.spc  = (i_byte == BYTE_SPACE) ? OB'(1) : '0;
                    v.tab  = (i_byte == BYTE_TAB);
                end else if (i_byte == BYTE_HASH) begin
                    v.mode = M_COMMENT;
                end else if (is_ind(i_byte)) begin
                    v.mode = M_IND;
                    v.lead = i_byte;
                end else if (is_safe(i_byte)) begin
                    v.mode = M_SCALAR;
                    v.lead = i_byte;
                end else begin
                    n_toks[n_cnt[TOK_IDX_W-1:0]] = mk_tok(KIND_ERROR, p, '0, '0);
                    n_cnt  = n_cnt + TOK_CNT_W'(1);
                    v.mode = M_ERROR;
                end
            end

            n_pos = e;

            // end of stream closes whatever is still open
            if (i_final && v.mode != M_ERROR) begin
                unique case (v.mode)
                    M_CR: begin
                        n_toks[n_cnt[TOK_IDX_W-1:0]] =
                            mk_tok(KIND_NEWLINE, v.start, OB'(1), '0);
                        n_cnt = n_cnt + TOK_CNT_W'(1);
                    end
                    M_BLANKS: begin
                        n_toks[n_cnt[TOK_IDX_W-1:0]] =
                            mk_tok(KIND_BLANKS, v.start, e - v.start, run_indent(v));
                        n_cnt = n_cnt + TOK_CNT_W'(1);
                    end
                    M_IND: begin
                        n_toks[n_cnt[TOK_IDX_W-1:0]] =
                            mk_tok(ind_kind(v.lead), v.start, OB'(1), '0);
                        n_cnt = n_cnt + TOK_CNT_W'(1);
                    end
                    M_SCALAR: begin
                        pr = close_pair(v, v.colon ? (e - OB'(1)) : e);
                        n_toks[n_cnt[TOK_IDX_W-1:0]] = pr.first;
                        n_cnt = n_cnt + TOK_CNT_W'(1);
                        if (pr.has_second) begin
                            n_toks[n_cnt[TOK_IDX_W-1:0]] = pr.second;
                            n_cnt = n_cnt + TOK_CNT_W'(1);
                        end
                        if (v.colon) begin
                            n_toks[n_cnt[TOK_IDX_W-1:0]] =
                                mk_tok(KIND_VALUE, e - OB'(1), OB'(1), '0);
                            n_cnt = n_cnt + TOK_CNT_W'(1);
                        end
                    end
                    M_COMMENT: begin
                        n_toks[n_cnt[TOK_IDX_W-1:0]] =
                            mk_tok(KIND_COMMENT, v.start, e - v.start, '0);
                        n_cnt = n_cnt + TOK_CNT_W'(1);
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (i_final) begin
            v     = lex_clear();
            n_pos = '0;
        end
        n_st = v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= lex_clear();
            r_pos <= '0;
        end else if (accept) begin
            r_st  <= n_st;
            r_pos <= n_pos;
        end
    end

    assign o_push         = accept && (n_cnt != '0);
    assign o_bundle.toks  = n_toks;
    assign o_bundle.count = n_cnt;
    assign o_bundle.fin   = i_final;

endmodule
`default_nettype wire

### hw/rtl/ytl_queue.sv
`default_nettype none
module ytl_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ytl_pkg::t_bundle  i_wr_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output ytl_pkg::t_bundle       o_rd_data
);
    import ytl_pkg::*;

    t_bundle            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QPTR_W:0]    r_count;
    logic [QPTR_W:0]    n_count;

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + (QPTR_W+1)'(1);
            2'b01:   n_count = r_count - (QPTR_W+1)'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_full    = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_rd_data = r_mem[r_rd_ptr];

endmodule
`default_nettype wire

### hw/rtl/ytl_back.sv
`default_nettype none
module ytl_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire ytl_pkg::t_bundle  i_q_data,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output ytl_pkg::t_token        o_token,
    output logic                   o_run_last,
    output logic                   o_stream_done
);
    import ytl_pkg::*;

    t_bundle                r_bundle;
    logic                   r_valid;
    logic [TOK_IDX_W-1:0]   r_idx;
    logic                   take;
    logic                   last;
    logic                   load;

    assign take = r_valid && i_ready;
    assign last = ({1'b0, r_idx} == (r_bundle.count - TOK_CNT_W'(1)));
    // next bundle loads when none is held or as the last token of the current one leaves
    assign load = i_q_valid && (!r_valid || (take && last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + TOK_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bundle <= i_q_data;
        end
    end

    assign o_pop         = load;
    assign o_valid       = r_valid;
    assign o_token       = r_bundle.toks[r_idx];
    assign o_run_last    = last;
    assign o_stream_done = last && r_bundle.fin;

endmodule
`default_nettype wire

### hw/rtl/yaml_token_lexer_core.sv
// block-style yaml tokeniser, one text byte per transaction in, one token per
// transaction out
// input stream: tdata carries the byte, tlast marks the final byte of a text
// output stream: tdata carries offset, length and indent, tuser the token kind
// and the end-of-stream flag, tlast marks the last token raised by one byte
// the front lexer takes a byte every cycle while its four-entry bundle queue
// has room; each byte yields a bundle of zero to four tokens
// the back end registers a bundle and sends its tokens one per cycle while the
// receiver is ready; a token passes the queue memory, then the bundle register
// sustained rate is one byte per cycle while bytes give at most one token and
// the receiver is ready; a byte giving more tokens holds the back end until all
// are sent; tokens are reported once their end is known, often one byte later
// when the receiver stalls, tready drops once four bundles wait in the queue
// behind the one held at the output stage; nothing is lost or repeated
// reset clears the lexer state, the queue and the output stage; the next byte
// opens a new stream at offset zero, as does the byte after a final byte
`default_nettype none
module yaml_token_lexer_core #(
    parameter int OFFSET_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // text_byte
    input  wire logic        i_s_axis_tlast,   // final_byte
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // token_offset [15:0], token_length [31:16], indent_width [48:32], zero pad
    output logic [55:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast,   // run_last
    output logic [3:0]       o_m_axis_tuser    // token_kind [2:0], stream_done [3]
);
    import ytl_pkg::*;

    t_bundle  front_bundle;
    t_bundle  queue_bundle;
    logic     push;
    logic     full;
    logic     pop;
    logic     queue_valid;
    t_token   token;
    logic     run_last;
    logic     stream_done;

    ytl_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_byte   (i_s_axis_tdata),
        .i_final  (i_s_axis_tlast),
        .i_full   (full),
        .o_push   (push),
        .o_bundle (front_bundle)
    );

    ytl_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (front_bundle),
        .o_full    (full),
        .i_pop     (pop),
        .o_valid   (queue_valid),
        .o_rd_data (queue_bundle)
    );

    ytl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (queue_valid),
        .i_q_data      (queue_bundle),
        .o_pop         (pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_token       (token),
        .o_run_last    (run_last),
        .o_stream_done (stream_done)
    );

    assign o_m_axis_tdata = {7'd0, token.indent, token.length, token.offset};
    assign o_m_axis_tlast = run_last;
    assign o_m_axis_tuser = {stream_done, token.kind};

endmodule
`default_nettype wire

### test/tb_yaml_token_lexer_core.sv
`default_nettype none
module tb_yaml_token_lexer_core;
    import ytl_pkg::*;

    localparam int          OFFSET_BITS   = 16;
    localparam int unsigned POS_LIMIT     = (1 << OFFSET_BITS) - 1;
    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          IDLE_PCT      = 16;
    localparam int          RANDOM_BYTES  = 150;
    localparam int          BURST_BYTES   = 100;
    localparam int          DRAIN_CYCLES  = 16;

    typedef enum {
        LX_IDLE,
        LX_CR,
        LX_BLANKS,
        LX_IND,
        LX_SCALAR,
        LX_COMMENT,
        LX_ERROR
    } t_lx_mode;

    typedef struct {
        t_kind              kind;
        logic [15:0]        offset;
        logic [15:0]        length;
        logic [IND_W-1:0]   indent;
        bit                 last;
        bit                 done;
    } t_exp_token;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [7:0]  i_s_axis_tdata  = '0;
    logic        i_s_axis_tlast  = 1'b0;
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [55:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic [3:0]  o_m_axis_tuser;

    // lexer state mirrored by the predictor
    t_lx_mode    lx_mode;
    int unsigned lx_pos;
    int unsigned lx_start;
    int unsigned lx_trail;
    int unsigned lx_spaces;
    logic [7:0]  lx_lead;
    bit          lx_prior_blank;
    bit          lx_tab;
    bit          lx_colon;

    t_exp_token  step_tokens[$];
    t_exp_token  pending_tokens[$];
    logic [7:0]  text_q[$];

    int          tx_idle_pct = IDLE_PCT;
    int          rx_idle_pct = IDLE_PCT;
    int          fail_count;
    int          bytes_sent;
    int          streams_sent;
    int          tokens_checked;
    int          cycle_count;

    yaml_token_lexer_core #(
        .OFFSET_BITS(OFFSET_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit is_blank(logic [7:0] b);
        return b == BYTE_SPACE || b == BYTE_TAB;
    endfunction

    function automatic bit is_break(logic [7:0] b);
        return b == BYTE_LF || b == BYTE_CR;
    endfunction

    function automatic bit is_safe(logic [7:0] b);
        return b > BYTE_SPACE && b <= BYTE_TILDE;
    endfunction

    function automatic bit is_indicator(logic [7:0] b);
        return b == BYTE_DASH || b == BYTE_QMARK || b == BYTE_COLON;
    endfunction

    function automatic t_kind indicator_kind(logic [7:0] b);
        if (b == BYTE_DASH) return KIND_SEQUENCE;
        if (b == BYTE_QMARK) return KIND_KEY;
        return KIND_VALUE;
    endfunction

    function automatic logic [IND_W-1:0] run_indent();
        return lx_tab ? {IND_W{1'b1}} : lx_spaces[IND_W-1:0];
    endfunction

    function automatic void emit_token(t_kind kind, int unsigned off, int unsigned len,
                                       logic [IND_W-1:0] indent);
        t_exp_token t;
        if (step_tokens.size() < MAX_TOKS) begin
            t.kind   = kind;
            t.offset = off[15:0];
            t.length = len[15:0];
            t.indent = indent;
            t.last   = 1'b0;
            t.done   = 1'b0;
            step_tokens.push_back(t);
        end
    endfunction

    function automatic void clear_lexer();
        lx_mode        = LX_IDLE;
        lx_pos         = 0;
        lx_start       = 0;
        lx_lead        = '0;
        lx_trail       = 0;
        lx_prior_blank = 1'b0;
        lx_spaces      = 0;
        lx_tab         = 1'b0;
        lx_colon       = 1'b0;
    endfunction

    function automatic void open_token(logic [7:0] b, int unsigned p);
        lx_start       = p;
        lx_spaces      = 0;
        lx_tab         = 1'b0;
        lx_trail       = 0;
        lx_prior_blank = 1'b0;
        lx_colon       = 1'b0;
        lx_mode        = LX_IDLE;
        if (b == BYTE_LF) begin
            emit_token(KIND_NEWLINE, p, 1, '0);
        end else if (b == BYTE_CR) begin
            lx_mode = LX_CR;
        end else if (is_blank(b)) begin
            lx_mode   = LX_BLANKS;
            lx_spaces = (b == BYTE_SPACE) ? 1 : 0;
            lx_tab    = (b == BYTE_TAB);
        end else if (b == BYTE_HASH) begin
            lx_mode = LX_COMMENT;
        end else if (is_indicator(b)) begin
            lx_mode = LX_IND;
            lx_lead = b;
        end else if (is_safe(b)) begin
            lx_mode = LX_SCALAR;
            lx_lead = b;
        end else begin
            emit_token(KIND_ERROR, p, 0, '0);
            lx_mode = LX_ERROR;
        end
    endfunction

    // endp is the offset just past the raw scalar bytes
    function automatic void close_scalar(int unsigned endp);
        int unsigned len;
        len = endp - lx_start - lx_trail;
        if (len == 1 && is_indicator(lx_lead))
            emit_token(indicator_kind(lx_lead), lx_start, 1, '0);
        else
            emit_token(KIND_SCALAR, lx_start, len, '0);
        if (lx_trail > 0)
            emit_token(KIND_BLANKS, endp - lx_trail, lx_trail, run_indent());
        lx_mode = LX_IDLE;
    endfunction

    function automatic void clear_trail();
        lx_trail       = 0;
        lx_spaces      = 0;
        lx_tab         = 1'b0;
        lx_prior_blank = 1'b0;
    endfunction

    function automatic void scalar_byte(logic [7:0] b, int unsigned p);
        if (lx_colon) begin
            lx_colon = 1'b0;
            if (is_blank(b) || is_break(b)) begin
                close_scalar(p - 1);
                emit_token(KIND_VALUE, p - 1, 1, '0);
                open_token(b, p);
                return;
            end
            clear_trail();
        end
        if (is_break(b) || (b == BYTE_HASH && lx_prior_blank)) begin
            close_scalar(p);
            open_token(b, p);
        end else if (b == BYTE_COLON) begin
            lx_colon = 1'b1;
        end else if (is_blank(b)) begin
            lx_trail++;
            if (b == BYTE_SPACE) lx_spaces++;
            else lx_tab = 1'b1;
            lx_prior_blank = 1'b1;
        end else begin
            clear_trail();
        end
    endfunction

    function automatic void lex_byte(logic [7:0] b, int unsigned p);
        int unsigned s;
        s = lx_start;
        case (lx_mode)
            LX_CR: begin
                if (b == BYTE_LF) begin
                    emit_token(KIND_NEWLINE, s, 2, '0);
                    lx_mode = LX_IDLE;
                end else begin
                    emit_token(KIND_NEWLINE, s, 1, '0);
                    open_token(b, p);
                end
            end
            LX_BLANKS: begin
                if (is_blank(b)) begin
                    if (b == BYTE_SPACE) lx_spaces++;
                    else lx_tab = 1'b1;
                end else begin
                    emit_token(KIND_BLANKS, s, p - s, run_indent());
                    open_token(b, p);
                end
            end
            LX_IND: begin
                if (is_safe(b)) begin
                    lx_mode = LX_SCALAR;
                    clear_trail();
                    lx_colon = (b == BYTE_COLON);
                end else begin
                    emit_token(indicator_kind(lx_lead), s, 1, '0);
                    open_token(b, p);
                end
            end
            LX_SCALAR: scalar_byte(b, p);
            LX_COMMENT: begin
                if (is_break(b)) begin
                    emit_token(KIND_COMMENT, s, p - s, '0);
                    open_token(b, p);
                end
            end
            default: open_token(b, p);
        endcase
    endfunction

    // close everything still open once the stream has ended at length e
    function automatic void flush_stream(int unsigned e);
        int unsigned s;
        s = lx_start;
        case (lx_mode)
            LX_CR:      emit_token(KIND_NEWLINE, s, 1, '0);
            LX_BLANKS:  emit_token(KIND_BLANKS, s, e - s, run_indent());
            LX_IND:     emit_token(indicator_kind(lx_lead), s, 1, '0);
            LX_SCALAR: begin
                if (lx_colon) begin
                    close_scalar(e - 1);
                    emit_token(KIND_VALUE, e - 1, 1, '0);
                end else begin
                    close_scalar(e);
                end
            end
            LX_COMMENT: emit_token(KIND_COMMENT, s, e - s, '0);
            default: ;
        endcase
    endfunction

    function automatic void lex_predict(logic [7:0] b, bit fin);
        int unsigned p;
        step_tokens.delete();
        if (lx_mode == LX_ERROR) begin
            if (fin) emit_token(KIND_ERROR, lx_start, 0, '0);
        end else if (lx_pos >= POS_LIMIT) begin
            // offset range exhausted: open token is dropped
            lx_start = POS_LIMIT;
            lx_mode  = LX_ERROR;
            emit_token(KIND_ERROR, lx_start, 0, '0);
        end else begin
            p = lx_pos;
            lex_byte(b, p);
            lx_pos = p + 1;
            if (fin && lx_mode != LX_ERROR) flush_stream(p + 1);
        end
        if (fin) clear_lexer();
        if (step_tokens.size() > 0) begin
            step_tokens[step_tokens.size() - 1].last = 1'b1;
            step_tokens[step_tokens.size() - 1].done = fin;
        end
        foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
    endfunction

    // ---------------------------------------------------------------- checker

    always @(posedge i_clk) begin
        t_exp_token want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            tokens_checked++;
            if (pending_tokens.size() == 0) begin
                $error("unexpected token: kind %0d offset %0d length %0d",
                       o_m_axis_tuser[2:0], o_m_axis_tdata[15:0], o_m_axis_tdata[31:16]);
                fail_count++;
            end else begin
                want = pending_tokens.pop_front();
                if (o_m_axis_tuser[2:0] !== want.kind) begin
                    $error("token_kind: expected %0d, got %0d", want.kind, o_m_axis_tuser[2:0]);
                    fail_count++;
                end
                if (o_m_axis_tdata[15:0] !== want.offset) begin
                    $error("token_offset: expected %0d, got %0d",
                           want.offset, o_m_axis_tdata[15:0]);
                    fail_count++;
                end
                if (o_m_axis_tdata[31:16] !== want.length) begin
                    $error("token_length: expected %0d, got %0d",
                           want.length, o_m_axis_tdata[31:16]);
                    fail_count++;
                end
                if (o_m_axis_tdata[48:32] !== want.indent) begin
                    $error("indent_width: expected %0d, got %0d",
                           $signed(want.indent), $signed(o_m_axis_tdata[48:32]));
                    fail_count++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("run_last: expected %0d, got %0d", want.last, o_m_axis_tlast);
                    fail_count++;
                end
                if (o_m_axis_tuser[3] !== want.done) begin
                    $error("stream_done: expected %0d, got %0d", want.done, o_m_axis_tuser[3]);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- sender

    task automatic send_byte(input logic [7:0] b, input bit fin);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        lex_predict(b, fin);
        bytes_sent++;
        if (fin) streams_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    function automatic void load_text(string s);
        foreach (s[i]) text_q.push_back(s[i]);
    endfunction

    // ---------------------------------------------------------------- text generator

    function automatic void push_scalar();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(0, 5) == 0) text_q.push_back(BYTE_SPACE);
            text_q.push_back(8'($urandom_range(33, 126)));
        end
    endfunction

    function automatic void push_line();
        repeat ($urandom_range(0, 4)) text_q.push_back(BYTE_SPACE);
        if ($urandom_range(0, 7) == 0) text_q.push_back(BYTE_TAB);
        case ($urandom_range(0, 3))
            0: begin
                text_q.push_back(BYTE_DASH);
                text_q.push_back(BYTE_SPACE);
            end
            1: begin
                text_q.push_back(BYTE_QMARK);
                text_q.push_back(BYTE_SPACE);
            end
            default: ;
        endcase
        push_scalar();
        if ($urandom_range(0, 1)) begin
            text_q.push_back(BYTE_COLON);
            if ($urandom_range(0, 3) != 0) begin
                text_q.push_back(BYTE_SPACE);
                push_scalar();
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) text_q.push_back(BYTE_SPACE);
            text_q.push_back(BYTE_HASH);
            push_scalar();
        end
        repeat ($urandom_range(0, 2))
            text_q.push_back($urandom_range(0, 1) ? BYTE_SPACE : BYTE_TAB);
        case ($urandom_range(0, 2))
            0: text_q.push_back(BYTE_LF);
            1: text_q.push_back(BYTE_CR);
            default: begin
                text_q.push_back(BYTE_CR);
                text_q.push_back(BYTE_LF);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    // key, sequence and value indicators, colon rules, colon pending at the end
    task automatic test_indicators_and_values();
        load_text("? k: \t-x:");
        send_text();
        load_text("-\n!:~:");
        send_text();
        load_text("x");
        send_text();
    endtask

    // trailing blanks with a tab, comment after a blank, raw bytes in a
    // comment, cr lf and a lone cr at the end of the stream
    task automatic test_blanks_comments_breaks();
        load_text("a\t #");
        text_q.push_back(8'h80);
        load_text("\r\n\r");
        send_text();
    endtask

    // a bad byte, then ignored bytes up to the final one, and a lone bad final byte
    task automatic test_bad_bytes();
        load_text("\n");
        text_q.push_back(8'h00);
        load_text("zz");
        send_text();
        text_q.push_back(8'hff);
        send_text();
    endtask

    // mostly well-formed block text with random content, some noise and
    // some streams cut short
    task automatic test_random_streams(input int n_bytes);
        int start_bytes;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < n_bytes) begin
            repeat ($urandom_range(1, 4)) push_line();
            if ($urandom_range(0, 2) == 0) void'(text_q.pop_back());
            if ($urandom_range(0, 3) == 0)
                text_q.insert($urandom_range(0, text_q.size()), 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 5) == 0)
                text_q = text_q[0:$urandom_range(0, text_q.size() - 1)];
            send_text();
        end
    endtask

    // random streams with neither side ever idling
    task automatic test_back_to_back_burst();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_streams(BURST_BYTES);
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        clear_lexer();
        test_indicators_and_values();
        test_blanks_comments_breaks();
        test_bad_bytes();
        test_random_streams(RANDOM_BYTES);
        test_back_to_back_burst();
        i_s_axis_tvalid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("lexed %0d bytes in %0d streams, %0d tokens checked",
                 bytes_sent, streams_sent, tokens_checked);
        $display("included bad bytes, cr/lf forms, colons, comments and a burst with no idling");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

### files.f
hw/rtl/ytl_pkg.sv
hw/rtl/ytl_front.sv
hw/rtl/ytl_queue.sv
hw/rtl/ytl_back.sv
hw/rtl/yaml_token_lexer_core.sv
test/tb_yaml_token_lexer_core.sv
